>>> hdl/ebws_pkg.sv
// Shared types and constants for the embedding bag weighted sum unit.
// Holds command and state types used by the front end, back end and top level.
// No dependencies.
package ebws_pkg;

    localparam int ROW_W = 12;
    localparam int COL_W = 6;
    localparam int VAL_W = 16;
    localparam int ACC_W = 40;
    localparam int OUT_W = 32;
    localparam int CNT_W = 16;
    localparam int DIM_W = 7;
    localparam int DIV_W = 41;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_ENTRY = 2'd1;
    localparam logic [1:0] MODE_CLOSE = 2'd2;

    localparam logic REG_DIM_IN_USE   = 1'b0;
    localparam logic REG_AVERAGE_MODE = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_ENTRY,
        OP_CLOSE
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] weight;
        logic                    last;
        logic                    gather;
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_GATHER,
        B_DRAIN,
        B_CREAD,
        B_CDATA,
        B_CDIV
    } back_state_t;

endpackage

>>> hdl/ebws_front.sv
// Front end: accepts requests, classifies them and queues commands.
// Depends on ebws_pkg.
module ebws_front #(
    parameter int TABLE_ROWS = 4096,
    parameter int MAX_DIM    = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        mode,
    input  logic [ebws_pkg::ROW_W-1:0]        row_index,
    input  logic [ebws_pkg::COL_W-1:0]        column,
    input  logic signed [ebws_pkg::VAL_W-1:0] table_value,
    input  logic signed [ebws_pkg::VAL_W-1:0] weight,
    input  logic                              last_of_bag,
    output ebws_pkg::cmd_t                    cmd,
    output logic                              cmd_valid,
    input  logic                              cmd_pop
);

    localparam int QD = 2;

    ebws_pkg::cmd_t q_reg [QD];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           accept;
    logic           keep;
    logic           row_ok;
    logic           push;
    ebws_pkg::cmd_t new_cmd;

    assign busy      = (cnt_reg == 2'(QD));
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign accept    = start && !busy;
    assign row_ok    = (32'(row_index) < 32'(TABLE_ROWS));

    // Classify the request and drop what changes nothing
    always_comb
    begin
        new_cmd.row    = row_index;
        new_cmd.col    = column;
        new_cmd.value  = table_value;
        new_cmd.weight = weight;
        new_cmd.last   = last_of_bag;
        new_cmd.gather = row_ok;
        new_cmd.op     = ebws_pkg::OP_LOAD;
        keep           = 1'b0;
        case (mode)
            ebws_pkg::MODE_LOAD:
            begin
                new_cmd.op = ebws_pkg::OP_LOAD;
                keep       = row_ok && (32'(column) < 32'(MAX_DIM));
            end
            ebws_pkg::MODE_ENTRY:
            begin
                new_cmd.op = ebws_pkg::OP_ENTRY;
                keep       = 1'b1;
            end
            ebws_pkg::MODE_CLOSE:
            begin
                new_cmd.op = ebws_pkg::OP_CLOSE;
                keep       = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = accept && keep;

    // Advance queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

>>> hdl/ebws_div.sv
// Restoring divider, one quotient bit per cycle, for the bag mean.
// Depends on ebws_pkg.
module ebws_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             go,
    input  logic [ebws_pkg::DIV_W-1:0]       dividend,
    input  logic [ebws_pkg::CNT_W-1:0]       divisor,
    output logic                             done,
    output logic [ebws_pkg::DIV_W-1:0]       quotient
);

    logic                             run_reg, run_next;
    logic                             done_reg, done_next;
    logic [5:0]                       cnt_reg, cnt_next;
    logic [ebws_pkg::DIV_W-1:0]       dq_reg, dq_next;
    logic [ebws_pkg::CNT_W-1:0]       rem_reg, rem_next;
    logic [ebws_pkg::CNT_W-1:0]       den_reg, den_next;
    logic [ebws_pkg::CNT_W:0]         rem_sh;
    logic                             ge;

    assign done     = done_reg;
    assign quotient = dq_reg;

    // Shift in one dividend bit and subtract when it fits
    always_comb
    begin
        rem_sh    = {rem_reg, dq_reg[ebws_pkg::DIV_W-1]};
        ge        = (rem_sh >= {1'b0, den_reg});
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = 6'd0;
            dq_next  = dividend;
            rem_next = '0;
            den_next = divisor;
        end
        else if (run_reg)
        begin
            dq_next  = {dq_reg[ebws_pkg::DIV_W-2:0], ge};
            rem_next = ge ? ebws_pkg::CNT_W'(rem_sh - {1'b0, den_reg})
                          : ebws_pkg::CNT_W'(rem_sh);
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(ebws_pkg::DIV_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

>>> hdl/ebws_back.sv
// Back end: table memory, gather-accumulate pipeline and bag close sequencer.
// Depends on ebws_pkg and ebws_div.
module ebws_back #(
    parameter int TABLE_ROWS = 4096,
    parameter int MAX_DIM    = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ebws_pkg::cmd_t                    cmd,
    input  logic                              cmd_valid,
    output logic                              cmd_pop,
    input  logic [ebws_pkg::DIM_W-1:0]        dim_act,
    input  logic                              average_mode,
    output logic                              result_valid,
    output logic signed [ebws_pkg::OUT_W-1:0] out_element,
    output logic [ebws_pkg::COL_W-1:0]        out_column,
    output logic                              last_of_row,
    output logic                              saturated
);

    localparam int DEPTH = TABLE_ROWS * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AccW  = ebws_pkg::ACC_W;
    localparam logic signed [AccW:0] ACC_HI = (AccW+1)'((64'sd1 <<< (AccW - 1)) - 64'sd1);
    localparam logic signed [AccW:0] ACC_LO = -ACC_HI - (AccW+1)'(1);
    localparam logic signed [41:0] OUT_HI = 42'sd2147483647;
    localparam logic signed [41:0] OUT_LO = -42'sd2147483648;

    ebws_pkg::back_state_t state_reg, state_next;

    logic signed [ebws_pkg::VAL_W-1:0] tbl_mem [DEPTH];
    logic signed [AccW-1:0]            acc_mem [MAX_DIM];
    logic signed [ebws_pkg::VAL_W-1:0] tbl_q;
    logic signed [AccW-1:0]            acc_q;
    logic                              accv_q;
    logic [MAX_DIM-1:0]                valid_reg;
    logic [MAX_DIM-1:0]                clip_reg;

    logic [ebws_pkg::ROW_W-1:0]        row_reg, row_next;
    logic signed [ebws_pkg::VAL_W-1:0] w_reg, w_next;
    logic                              last_reg, last_next;
    logic [ebws_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [ebws_pkg::DIM_W-1:0]        j_reg, j_next;
    logic                              neg_reg, neg_next;

    logic                              s1_valid_reg;
    logic [CW-1:0]                     s1_col_reg;
    logic                              s2_valid_reg;
    logic [CW-1:0]                     s2_col_reg;
    logic signed [31:0]                s2_prod_reg;
    logic signed [AccW-1:0]            s2_acc_reg;

    logic                              rv_reg, rv_next;
    logic signed [ebws_pkg::OUT_W-1:0] oe_reg, oe_next;
    logic [ebws_pkg::COL_W-1:0]        oc_reg, oc_next;
    logic                              ol_reg, ol_next;
    logic                              os_reg, os_next;

    logic                              issue;
    logic                              acc_rd;
    logic [CW-1:0]                     acc_rd_addr;
    logic                              tbl_we;
    logic [AW-1:0]                     tbl_addr;
    logic                              clear;
    logic                              last_col;
    logic                              col_clip;
    logic signed [AccW-1:0]            cur_v;
    logic [AccW-1:0]                   cur_mag;
    logic                              need_div;
    logic                              div_go;
    logic                              div_done;
    logic [ebws_pkg::DIV_W-1:0]        div_q;
    logic [ebws_pkg::DIV_W-1:0]        div_a;
    logic signed [41:0]                emit_v;
    logic signed [41:0]                div_s;
    logic signed [AccW:0]              s2_sum;
    logic signed [AccW-1:0]            s2_wr;
    logic                              s2_clip;

    assign result_valid = rv_reg;
    assign out_element  = oe_reg;
    assign out_column   = oc_reg;
    assign last_of_row  = ol_reg;
    assign saturated    = os_reg;

    assign last_col = (j_reg + 7'd1 == dim_act);
    assign col_clip = clip_reg[j_reg[CW-1:0]];
    assign cur_v    = accv_q ? acc_q : '0;
    assign cur_mag  = cur_v[AccW-1] ? AccW'(-cur_v) : AccW'(cur_v);
    assign need_div = !col_clip && average_mode && (count_reg != '0);
    assign div_a    = ebws_pkg::DIV_W'(cur_mag) + ebws_pkg::DIV_W'(count_reg >> 1);
    assign div_s    = neg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ebws_pkg::B_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        ebws_pkg::OP_ENTRY:
                        begin
                            if (cmd.gather)
                                state_next = ebws_pkg::B_GATHER;
                            else if (cmd.last)
                                state_next = ebws_pkg::B_CREAD;
                        end
                        ebws_pkg::OP_CLOSE: state_next = ebws_pkg::B_CREAD;
                        default:            state_next = ebws_pkg::B_IDLE;
                    endcase
                end
            end
            ebws_pkg::B_GATHER:
            begin
                if (last_col)
                    state_next = ebws_pkg::B_DRAIN;
            end
            ebws_pkg::B_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                    state_next = last_reg ? ebws_pkg::B_CREAD : ebws_pkg::B_IDLE;
            end
            ebws_pkg::B_CREAD:
            begin
                state_next = ebws_pkg::B_CDATA;
            end
            ebws_pkg::B_CDATA:
            begin
                if (need_div)
                    state_next = ebws_pkg::B_CDIV;
                else
                    state_next = last_col ? ebws_pkg::B_IDLE : ebws_pkg::B_CREAD;
            end
            ebws_pkg::B_CDIV:
            begin
                if (div_done)
                    state_next = last_col ? ebws_pkg::B_IDLE : ebws_pkg::B_CREAD;
            end
            default:
            begin
                state_next = ebws_pkg::B_IDLE;
            end
        endcase
    end

    // Datapath control and result registers
    always_comb
    begin
        cmd_pop    = 1'b0;
        row_next   = row_reg;
        w_next     = w_reg;
        last_next  = last_reg;
        count_next = count_reg;
        j_next     = j_reg;
        neg_next   = neg_reg;
        issue      = 1'b0;
        acc_rd     = 1'b0;
        tbl_we     = 1'b0;
        clear      = 1'b0;
        div_go     = 1'b0;
        rv_next    = 1'b0;
        oe_next    = oe_reg;
        oc_next    = oc_reg;
        ol_next    = ol_reg;
        os_next    = os_reg;
        emit_v     = '0;
        tbl_addr   = AW'(row_reg) * AW'(MAX_DIM) + AW'(j_reg);
        acc_rd_addr = j_reg[CW-1:0];
        case (state_reg)
            ebws_pkg::B_IDLE:
            begin
                tbl_addr = AW'(cmd.row) * AW'(MAX_DIM) + AW'(cmd.col);
                if (cmd_valid)
                begin
                    cmd_pop   = 1'b1;
                    row_next  = cmd.row;
                    w_next    = cmd.weight;
                    last_next = cmd.last;
                    j_next    = '0;
                    case (cmd.op)
                        ebws_pkg::OP_LOAD:  tbl_we = 1'b1;
                        ebws_pkg::OP_ENTRY:
                        begin
                            if (count_reg != '1)
                                count_next = count_reg + 16'd1;
                        end
                        default:            tbl_we = 1'b0;
                    endcase
                end
            end
            ebws_pkg::B_GATHER:
            begin
                issue  = 1'b1;
                acc_rd = 1'b1;
                j_next = last_col ? '0 : j_reg + 7'd1;
            end
            ebws_pkg::B_CREAD:
            begin
                acc_rd = 1'b1;
            end
            ebws_pkg::B_CDATA:
            begin
                neg_next = cur_v[AccW-1];
                if (need_div)
                begin
                    div_go = 1'b1;
                end
                else
                begin
                    rv_next = 1'b1;
                    oc_next = j_reg[ebws_pkg::COL_W-1:0];
                    ol_next = last_col;
                    if (col_clip)
                    begin
                        oe_next = cur_v[AccW-1] ? OUT_LO[31:0] : OUT_HI[31:0];
                        os_next = 1'b1;
                    end
                    else
                    begin
                        emit_v = 42'(cur_v);
                        os_next = (emit_v > OUT_HI) || (emit_v < OUT_LO);
                        oe_next = (emit_v > OUT_HI) ? OUT_HI[31:0]
                                : (emit_v < OUT_LO) ? OUT_LO[31:0] : emit_v[31:0];
                    end
                    j_next = j_reg + 7'd1;
                    clear  = last_col;
                end
            end
            ebws_pkg::B_CDIV:
            begin
                if (div_done)
                begin
                    rv_next = 1'b1;
                    oc_next = j_reg[ebws_pkg::COL_W-1:0];
                    ol_next = last_col;
                    emit_v  = div_s;
                    os_next = (emit_v > OUT_HI) || (emit_v < OUT_LO);
                    oe_next = (emit_v > OUT_HI) ? OUT_HI[31:0]
                            : (emit_v < OUT_LO) ? OUT_LO[31:0] : emit_v[31:0];
                    j_next  = j_reg + 7'd1;
                    clear   = last_col;
                end
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
        if (clear)
            count_next = '0;
    end

    // Add the weighted element and clamp to the accumulator range
    always_comb
    begin
        s2_sum  = (AccW+1)'(s2_acc_reg) + (AccW+1)'(s2_prod_reg);
        s2_clip = (s2_sum > ACC_HI) || (s2_sum < ACC_LO);
        s2_wr   = (s2_sum > ACC_HI) ? ACC_HI[AccW-1:0]
                : (s2_sum < ACC_LO) ? ACC_LO[AccW-1:0] : s2_sum[AccW-1:0];
    end

    ebws_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_a),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ebws_pkg::B_IDLE;
            count_reg    <= '0;
            j_reg        <= '0;
            valid_reg    <= '0;
            clip_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            rv_reg       <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            j_reg        <= j_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            rv_reg       <= rv_next;
            last_reg     <= last_next;
            if (clear)
            begin
                valid_reg <= '0;
                clip_reg  <= '0;
            end
            else if (s2_valid_reg)
            begin
                valid_reg[s2_col_reg] <= 1'b1;
                if (s2_clip)
                    clip_reg[s2_col_reg] <= 1'b1;
            end
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        row_reg     <= row_next;
        w_reg       <= w_next;
        neg_reg     <= neg_next;
        oe_reg      <= oe_next;
        oc_reg      <= oc_next;
        ol_reg      <= ol_next;
        os_reg      <= os_next;
        s1_col_reg  <= j_reg[CW-1:0];
        s2_col_reg  <= s1_col_reg;
        s2_prod_reg <= 32'(w_reg) * 32'(tbl_q);
        s2_acc_reg  <= accv_q ? acc_q : '0;
    end

    // Table memory: write on load, read on gather
    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[tbl_addr] <= cmd.value;
        else
            tbl_q <= tbl_mem[tbl_addr];
    end

    // Accumulator memory: written from the last stage, read registered
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
            acc_mem[s2_col_reg] <= s2_wr;
        if (acc_rd)
        begin
            acc_q  <= acc_mem[acc_rd_addr];
            accv_q <= valid_reg[acc_rd_addr];
        end
    end

endmodule

>>> hdl/embedding_bag_weighted_sum_unit.sv
// Embedding bag weighted sum / mean unit: top level with configuration registers.
// Depends on ebws_pkg, ebws_front and ebws_back.
//
// Usage: drive start with mode and the request fields; a request is taken at
// a clock edge where start is high and busy is low. Mode 0 loads one Q8.8
// table element, mode 1 adds a weighted row into the bag, mode 2 closes an
// empty or pending bag. A bag entry flagged last_of_bag also closes the bag.
// Configuration is written through cfg_write, cfg_index and cfg_data: index 0
// is dim_in_use, index 1 is average_mode. The user must write it only while the
// unit is idle; the block does not enforce this. A two-entry command queue sits
// between the front end and the back end. The back end writes a load into the
// table as it dispatches it. A bag entry is dispatched, then reads its row one
// word per cycle from the single table port and drains the multiply-accumulate
// pipeline (d = dim_in_use, limited to 1..MAX_DIM). Closing a bag emits d
// results; when averaging a nonempty bag, each unclipped column goes through
// the one-bit-per-cycle divider.
// Each result is shown for one cycle with result_valid high; the receiver
// cannot stall. Reset clears the accumulators, count and queue; the table
// contents are undefined until loaded.
module embedding_bag_weighted_sum_unit #(
    parameter int TABLE_ROWS = 4096,
    parameter int MAX_DIM    = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        mode,
    input  logic [ebws_pkg::ROW_W-1:0]        row_index,
    input  logic [ebws_pkg::COL_W-1:0]        column,
    input  logic signed [ebws_pkg::VAL_W-1:0] table_value,
    input  logic signed [ebws_pkg::VAL_W-1:0] weight,
    input  logic                              last_of_bag,
    input  logic                              cfg_write,
    input  logic                              cfg_index,
    input  logic [ebws_pkg::DIM_W-1:0]        cfg_data,
    output logic                              result_valid,
    output logic signed [ebws_pkg::OUT_W-1:0] out_element,
    output logic [ebws_pkg::COL_W-1:0]        out_column,
    output logic                              last_of_row,
    output logic                              saturated
);

    logic [ebws_pkg::DIM_W-1:0] dim_reg;
    logic                       avg_reg;
    logic [ebws_pkg::DIM_W-1:0] dim_act;
    ebws_pkg::cmd_t             cmd;
    logic                       cmd_valid;
    logic                       cmd_pop;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= 7'd64;
            avg_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ebws_pkg::REG_DIM_IN_USE:   dim_reg <= cfg_data;
                ebws_pkg::REG_AVERAGE_MODE: avg_reg <= cfg_data[0];
                default:                    avg_reg <= avg_reg;
            endcase
        end
    end

    // Limit the column count to 1..MAX_DIM
    assign dim_act = (dim_reg == '0) ? 7'd1
                   : (32'(dim_reg) > 32'(MAX_DIM)) ? 7'(MAX_DIM) : dim_reg;

    ebws_front #(
        .TABLE_ROWS (TABLE_ROWS),
        .MAX_DIM    (MAX_DIM)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .row_index   (row_index),
        .column      (column),
        .table_value (table_value),
        .weight      (weight),
        .last_of_bag (last_of_bag),
        .cmd         (cmd),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop)
    );

    ebws_back #(
        .TABLE_ROWS (TABLE_ROWS),
        .MAX_DIM    (MAX_DIM)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop),
        .dim_act      (dim_act),
        .average_mode (avg_reg),
        .result_valid (result_valid),
        .out_element  (out_element),
        .out_column   (out_column),
        .last_of_row  (last_of_row),
        .saturated    (saturated)
    );

endmodule

>>> sim/embedding_bag_weighted_sum_unit_test.sv
// Self-checking testbench for embedding_bag_weighted_sum_unit: table loads,
// weighted bag sums and means checked column by column against a local predictor.
// Depends on ebws_pkg and the embedding_bag_weighted_sum_unit RTL.
`timescale 1ns / 1ps

module embedding_bag_weighted_sum_unit_test;

    localparam int PERIOD = 12;
    localparam int SETTLE = 300;
    localparam logic [1:0] MODE_NOOP = 2'd3;
    localparam longint ACC_TOP = 64'sd549755813887;
    localparam longint ACC_BOT = -ACC_TOP - 1;
    localparam longint OUT_TOP = 64'sd2147483647;
    localparam longint OUT_BOT = -64'sd2147483648;

    typedef enum logic [1:0] { KIND_REQ, KIND_CFG, KIND_PAUSE } kind_t;

    typedef struct {
        kind_t                      kind;
        logic [1:0]                 mode;
        logic [ebws_pkg::ROW_W-1:0] row;
        logic [ebws_pkg::COL_W-1:0] col;
        logic [ebws_pkg::VAL_W-1:0] value;
        logic [ebws_pkg::VAL_W-1:0] wgt;
        logic                       last;
        int                         idle_pct;
        logic                       reg_idx;
        logic [ebws_pkg::DIM_W-1:0] reg_data;
    } request_t;

    typedef struct {
        logic [ebws_pkg::OUT_W-1:0] element;
        logic [ebws_pkg::COL_W-1:0] col;
        logic                       last;
        logic                       sat;
    } column_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] mode = '0;
    logic [ebws_pkg::ROW_W-1:0] row_index = '0;
    logic [ebws_pkg::COL_W-1:0] column = '0;
    logic signed [ebws_pkg::VAL_W-1:0] table_value = '0;
    logic signed [ebws_pkg::VAL_W-1:0] weight = '0;
    logic last_of_bag = 1'b0;
    logic cfg_write = 1'b0;
    logic cfg_index = 1'b0;
    logic [ebws_pkg::DIM_W-1:0] cfg_data = '0;
    logic result_valid;
    logic signed [ebws_pkg::OUT_W-1:0] out_element;
    logic [ebws_pkg::COL_W-1:0] out_column;
    logic last_of_row;
    logic saturated;

    embedding_bag_weighted_sum_unit DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .row_index(row_index), .column(column), .table_value(table_value),
        .weight(weight), .last_of_bag(last_of_bag), .cfg_write(cfg_write),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .result_valid(result_valid),
        .out_element(out_element), .out_column(out_column),
        .last_of_row(last_of_row), .saturated(saturated)
    );

    request_t       pending[$];
    column_result_t bag_results_due[$];
    int             loaded_rows[$];
    int             errors = 0;
    int             quiet = 0;

    // Predictor state
    logic [ebws_pkg::VAL_W-1:0] table_copy [0:262143];
    longint                     col_sums [64];
    bit                         col_clipped [64];
    int unsigned                bag_count;
    logic [ebws_pkg::DIM_W-1:0] dim_reg;
    logic                       avg_reg;

    initial begin
        forever #(PERIOD / 2) clk = ~clk;
    end

    function automatic int unsigned eff_dim();
        if (dim_reg == 0) return 1;
        if (dim_reg > 64) return 64;
        return dim_reg;
    endfunction

    // Emit the bag result for every column in use, then clear the bag
    task automatic close_bag();
        int unsigned d;
        longint v;
        longint mag;
        bit sat;
        column_result_t r;
        d = eff_dim();
        for (int j = 0; j < d; j++) begin
            v = col_sums[j];
            sat = 1'b0;
            if (col_clipped[j]) begin
                v = (v < 0) ? OUT_BOT : OUT_TOP;
                sat = 1'b1;
            end
            else begin
                if (avg_reg && bag_count != 0) begin
                    mag = (v < 0) ? -v : v;
                    mag = (mag + bag_count / 2) / bag_count;
                    v = (v < 0) ? -mag : mag;
                end
                if (v > OUT_TOP) begin v = OUT_TOP; sat = 1'b1; end
                if (v < OUT_BOT) begin v = OUT_BOT; sat = 1'b1; end
            end
            r.element = v[ebws_pkg::OUT_W-1:0];
            r.col = j[ebws_pkg::COL_W-1:0];
            r.last = (j + 1 == d);
            r.sat = sat;
            bag_results_due.push_back(r);
        end
        for (int j = 0; j < 64; j++) begin
            col_sums[j] = 0;
            col_clipped[j] = 1'b0;
        end
        bag_count = 0;
    endtask

    // Advance the predictor by one accepted request
    task automatic predict_bag(request_t q);
        longint w;
        longint e;
        longint s;
        if (q.mode == ebws_pkg::MODE_LOAD) begin
            table_copy[{q.row, q.col}] = q.value;
        end
        else if (q.mode == ebws_pkg::MODE_ENTRY) begin
            w = longint'($signed(q.wgt));
            for (int j = 0; j < eff_dim(); j++) begin
                e = longint'($signed(table_copy[{q.row, j[ebws_pkg::COL_W-1:0]}]));
                s = col_sums[j] + w * e;
                if (s > ACC_TOP) begin s = ACC_TOP; col_clipped[j] = 1'b1; end
                if (s < ACC_BOT) begin s = ACC_BOT; col_clipped[j] = 1'b1; end
                col_sums[j] = s;
            end
            if (bag_count < 65535) bag_count++;
            if (q.last) close_bag();
        end
        else if (q.mode == ebws_pkg::MODE_CLOSE) begin
            close_bag();
        end
    endtask

    // Driver: present requests, hold them until taken, apply register writes when idle
    always @(posedge clk or negedge rst_n) begin
        logic took;
        logic cfg_now;
        logic step_done;
        if (!rst_n) begin
            start <= 1'b0;
            cfg_write <= 1'b0;
            quiet <= 0;
        end
        else begin
            took = start && !busy;
            cfg_now = 1'b0;
            step_done = 1'b0;
            if (took) begin
                predict_bag(pending[0]);
                void'(pending.pop_front());
            end
            if (start && !took) begin
                // hold the request in place
            end
            else if (pending.size() == 0) begin
                start <= 1'b0;
            end
            else if (pending[0].kind == KIND_REQ) begin
                if ($urandom_range(99) < pending[0].idle_pct) begin
                    start <= 1'b0;
                end
                else begin
                    start <= 1'b1;
                    mode <= pending[0].mode;
                    row_index <= pending[0].row;
                    column <= pending[0].col;
                    table_value <= pending[0].value;
                    weight <= pending[0].wgt;
                    last_of_bag <= pending[0].last;
                end
            end
            else begin
                start <= 1'b0;
                if (!took && bag_results_due.size() == 0 && quiet >= SETTLE) begin
                    if (pending[0].kind == KIND_CFG) begin
                        cfg_now = 1'b1;
                        cfg_index <= pending[0].reg_idx;
                        cfg_data <= pending[0].reg_data;
                        if (pending[0].reg_idx == ebws_pkg::REG_DIM_IN_USE)
                            dim_reg = pending[0].reg_data;
                        else
                            avg_reg = pending[0].reg_data[0];
                    end
                    void'(pending.pop_front());
                    step_done = 1'b1;
                end
            end
            cfg_write <= cfg_now;
            if (step_done || bag_results_due.size() != 0 || start) quiet <= 0;
            else quiet <= quiet + 1;
        end
    end

    // Monitor: compare each result with the oldest expected column
    always @(posedge clk) begin
        column_result_t exp_r;
        if (rst_n && result_valid) begin
            if (bag_results_due.size() == 0) begin
                $error("unexpected result: out_element %0d column %0d", out_element, out_column);
                errors++;
            end
            else begin
                exp_r = bag_results_due.pop_front();
                if (out_element !== exp_r.element) begin
                    $error("out_element: expected %0d actual %0d",
                           $signed(exp_r.element), out_element);
                    errors++;
                end
                if (out_column !== exp_r.col) begin
                    $error("out_column: expected %0d actual %0d", exp_r.col, out_column);
                    errors++;
                end
                if (last_of_row !== exp_r.last) begin
                    $error("last_of_row: expected %0d actual %0d", exp_r.last, last_of_row);
                    errors++;
                end
                if (saturated !== exp_r.sat) begin
                    $error("saturated: expected %0d actual %0d", exp_r.sat, saturated);
                    errors++;
                end
            end
        end
    end

    function automatic request_t make_req(logic [1:0] m, int row, int col, int val,
                                          int wgt, bit last, int idle);
        request_t q;
        q.kind = KIND_REQ;
        q.mode = m;
        q.row = row[ebws_pkg::ROW_W-1:0];
        q.col = col[ebws_pkg::COL_W-1:0];
        q.value = val[ebws_pkg::VAL_W-1:0];
        q.wgt = wgt[ebws_pkg::VAL_W-1:0];
        q.last = last;
        q.idle_pct = idle;
        q.reg_idx = 1'b0;
        q.reg_data = '0;
        return q;
    endfunction

    task automatic push_cfg(logic idx, int data);
        request_t q;
        q = make_req(MODE_NOOP, 0, 0, 0, 0, 0, 0);
        q.kind = KIND_CFG;
        q.reg_idx = idx;
        q.reg_data = data[ebws_pkg::DIM_W-1:0];
        pending.push_back(q);
    endtask

    task automatic push_pause();
        request_t q;
        q = make_req(MODE_NOOP, 0, 0, 0, 0, 0, 0);
        q.kind = KIND_PAUSE;
        pending.push_back(q);
    endtask

    task automatic load_row(int row, int idle);
        for (int c = 0; c < 64; c++)
            pending.push_back(make_req(ebws_pkg::MODE_LOAD, row, c, $urandom, $urandom,
                                       $urandom_range(1), idle));
        loaded_rows.push_back(row);
    endtask

    // Mostly bag entries over loaded rows, with reloads, closes and noise
    task automatic random_traffic(int n, int idle);
        int pick;
        int row;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            row = loaded_rows[$urandom_range(loaded_rows.size() - 1)];
            if (pick < 15)
                pending.push_back(make_req(ebws_pkg::MODE_LOAD, row, $urandom_range(63),
                                           $urandom, $urandom, $urandom_range(1), idle));
            else if (pick < 18)
                pending.push_back(make_req(ebws_pkg::MODE_LOAD, $urandom_range(4095),
                                           $urandom_range(63), $urandom, $urandom,
                                           $urandom_range(1), idle));
            else if (pick < 23)
                pending.push_back(make_req(MODE_NOOP, $urandom_range(4095), $urandom_range(63),
                                           $urandom, $urandom, $urandom_range(1), idle));
            else if (pick < 33)
                pending.push_back(make_req(ebws_pkg::MODE_CLOSE, row, $urandom_range(63),
                                           $urandom, $urandom, $urandom_range(1), idle));
            else
                pending.push_back(make_req(ebws_pkg::MODE_ENTRY, row, $urandom_range(63),
                                           $urandom, $urandom, $urandom_range(99) < 25,
                                           idle));
        end
    endtask

    initial begin
        for (int j = 0; j < 64; j++) begin
            col_sums[j] = 0;
            col_clipped[j] = 1'b0;
        end
        bag_count = 0;
        dim_reg = 7'd64;
        avg_reg = 1'b0;

        // Phase one: sender idles often
        push_cfg(ebws_pkg::REG_DIM_IN_USE, 64);
        push_cfg(ebws_pkg::REG_AVERAGE_MODE, 0);
        for (int c = 0; c < 64; c++)
            pending.push_back(make_req(ebws_pkg::MODE_LOAD, 0, c,
                                       (c % 2) ? 16'h8000 : 16'h7fff, 0, c % 2, 33));
        loaded_rows.push_back(0);
        load_row(4095, 33);

        // Directed: empty bag, extreme weights, output clipping, close with pending
        pending.push_back(make_req(ebws_pkg::MODE_CLOSE, 0, 0, 0, 0, 0, 33));
        pending.push_back(make_req(ebws_pkg::MODE_ENTRY, 0, 0, 0, 16'h7fff, 1, 33));
        pending.push_back(make_req(ebws_pkg::MODE_ENTRY, 0, 0, 0, 16'h8000, 0, 33));
        pending.push_back(make_req(MODE_NOOP, 4095, 63, 16'hffff, 16'hffff, 1, 33));
        pending.push_back(make_req(ebws_pkg::MODE_ENTRY, 0, 0, 0, 16'h8000, 0, 33));
        pending.push_back(make_req(ebws_pkg::MODE_ENTRY, 0, 0, 0, 16'h8000, 1, 33));
        pending.push_back(make_req(ebws_pkg::MODE_ENTRY, 4095, 0, 0, 0, 0, 33));
        pending.push_back(make_req(ebws_pkg::MODE_ENTRY, 4095, 0, 0, 16'h0100, 0, 33));
        pending.push_back(make_req(ebws_pkg::MODE_CLOSE, 4095, 0, 0, 0, 1, 33));
        push_pause();
        push_cfg(ebws_pkg::REG_AVERAGE_MODE, 1);
        pending.push_back(make_req(ebws_pkg::MODE_ENTRY, 4095, 0, 0, 16'h0180, 0, 33));
        pending.push_back(make_req(ebws_pkg::MODE_ENTRY, 0, 0, 0, 16'hff00, 1, 33));
        pending.push_back(make_req(ebws_pkg::MODE_CLOSE, 0, 0, 0, 0, 0, 33));
        random_traffic(40, 33);

        // Phase two: sender idles more, dimension at its edges
        push_cfg(ebws_pkg::REG_DIM_IN_USE, 0);
        push_cfg(ebws_pkg::REG_AVERAGE_MODE, 0);
        random_traffic(20, 45);
        push_cfg(ebws_pkg::REG_DIM_IN_USE, 127);
        push_cfg(ebws_pkg::REG_AVERAGE_MODE, 1);
        random_traffic(20, 45);
        push_cfg(ebws_pkg::REG_DIM_IN_USE, $urandom_range(2, 63));
        random_traffic(20, 45);

        // Phase three: no idling, full width, random averaging
        push_cfg(ebws_pkg::REG_DIM_IN_USE, 64);
        push_cfg(ebws_pkg::REG_AVERAGE_MODE, $urandom_range(1));
        random_traffic(40, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || start) @(posedge clk);
        while (bag_results_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && bag_results_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hard time limit
    initial begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
